@@ rtl/core/gics_pkg.sv @@
// shared constants and codes for the grid inverse-cdf sampler
`default_nettype none

package gics_pkg;

  // operation codes carried in the input tuser
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // fixed field widths
  localparam int OP_W        = 2;
  localparam int DATA_W      = 32;
  localparam int POS_W       = 37;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 144;

  // shared multiplier: signed operands, low product bits kept
  localparam int MUL_W  = 33;
  localparam int PROD_W = 64;

endpackage : gics_pkg

`default_nettype wire

@@ rtl/core/gics_mul.sv @@
// shared signed multiplier with registered product
`default_nettype none

module gics_mul (
  input  wire logic                                clk,
  input  wire logic signed [gics_pkg::MUL_W-1:0]   mul_a,
  input  wire logic signed [gics_pkg::MUL_W-1:0]   mul_b,
  output logic         [gics_pkg::PROD_W-1:0]      mul_p
);

  logic signed [2*gics_pkg::MUL_W-1:0] prod;
  logic        [gics_pkg::PROD_W-1:0]  prod_r;

  // full signed product, low bits registered
  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= prod[gics_pkg::PROD_W-1:0];
  end

  assign mul_p = prod_r;

endmodule : gics_mul

`default_nettype wire

@@ rtl/core/grid_inverse_cdf_sampler.sv @@
// grid inverse-cdf sampler top level: weight store, sequencer and output register
//
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    tuser: op; tdata: weight, random_fraction
//  out_     out  out_tvalid/out_tready  tuser: found; tdata: pos_x, pos_y, pos_z, cell_weight
//  cfg_     in   cfg_wr_en              cfg_wr_data: step_size
//
// load, clear and unused codes are handled in the idle state.
// a sample scans n cells, n being at most the loaded count:
// one weight store read per cycle drives the running-sum scan; the target and the three
// positions go through one shared multiplier, one product per cycle.
// an empty-grid sample goes straight to emit. reset is synchronous; the store needs no clear.
// a waiting result holds the sequencer in its last state only when a new result is ready.
`default_nettype none

module grid_inverse_cdf_sampler #(
  parameter int POINTS_PER_DIM = 32,
  parameter int WEIGHT_BITS    = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input words
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [gics_pkg::IN_TDATA_W-1:0]    in_tdata,   // weight[31:0], random_fraction[63:32]
  input  wire logic [gics_pkg::OP_W-1:0]          in_tuser,   // op[1:0]
  // result words
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [gics_pkg::OUT_TDATA_W-1:0]        out_tdata,  // pos_x[36:0], pos_y[73:37],
                                                              // pos_z[110:74],
                                                              // cell_weight[142:111], zero[143]
  output logic [0:0]                              out_tuser,  // found[0]
  // configuration
  input  wire logic                               cfg_wr_en,
  input  wire logic [gics_pkg::DATA_W-1:0]        cfg_wr_data
);

  localparam int CELL_COUNT = POINTS_PER_DIM * POINTS_PER_DIM * POINTS_PER_DIM;
  localparam int IDX_W      = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int TOT_W      = WEIGHT_BITS + IDX_W;
  localparam int COORD_W    = $clog2(POINTS_PER_DIM);
  localparam int CENTRE     = (POINTS_PER_DIM - 1) / 2;
  localparam int MUL_W      = gics_pkg::MUL_W;
  localparam int PROD_W     = gics_pkg::PROD_W;
  localparam int POS_W      = gics_pkg::POS_W;
  localparam int DATA_W     = gics_pkg::DATA_W;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_MLO  = 10'b00_0000_0010,
    ST_MHI  = 10'b00_0000_0100,
    ST_TGT  = 10'b00_0000_1000,
    ST_SCAN = 10'b00_0001_0000,
    ST_PX   = 10'b00_0010_0000,
    ST_PY   = 10'b00_0100_0000,
    ST_PZ   = 10'b00_1000_0000,
    ST_PW   = 10'b01_0000_0000,
    ST_EMIT = 10'b10_0000_0000
  } state_t;

  state_t                   state_r,   state_nxt;
  logic [CNT_W-1:0]         count_r,   count_nxt;
  logic [TOT_W-1:0]         total_r,   total_nxt;
  logic [DATA_W-1:0]        step_r,    step_nxt;
  logic [DATA_W-1:0]        frac_r,    frac_nxt;
  logic [PROD_W-1:0]        lo_prod_r, lo_prod_nxt;
  logic [TOT_W-1:0]         target_r,  target_nxt;
  logic [TOT_W-1:0]         sum_r,     sum_nxt;
  logic [IDX_W-1:0]         chk_r,     chk_nxt;
  logic [IDX_W-1:0]         addr_r,    addr_nxt;
  logic [COORD_W-1:0]       ci_r,      ci_nxt;
  logic [COORD_W-1:0]       cj_r,      cj_nxt;
  logic [COORD_W-1:0]       ck_r,      ck_nxt;
  logic                     fnd_s_r,   fnd_s_nxt;
  logic [POS_W-1:0]         px_s_r,    px_s_nxt;
  logic [POS_W-1:0]         py_s_r,    py_s_nxt;
  logic [POS_W-1:0]         pz_s_r,    pz_s_nxt;
  logic [WEIGHT_BITS-1:0]   w_s_r,     w_s_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_found_r;
  logic [POS_W-1:0]         out_x_r, out_y_r, out_z_r;
  logic [WEIGHT_BITS-1:0]   out_w_r;

  logic [WEIGHT_BITS-1:0]   mem [CELL_COUNT];
  logic [WEIGHT_BITS-1:0]   rdata_r;

  logic                     in_acc;
  logic [gics_pkg::OP_W-1:0] op;
  logic [WEIGHT_BITS-1:0]   in_weight;
  logic                     store_wr;
  logic                     emit_ok;
  logic [PROD_W-1:0]        tot_ext;
  logic [PROD_W-1:0]        tgt_sum;
  logic [TOT_W-1:0]         scan_sum;
  logic                     scan_hit;
  logic                     scan_last;
  logic                     addr_end;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic signed [MUL_W-1:0]  off_i, off_j, off_k, step_op;

  // input decode
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign op        = in_tuser;
  assign in_weight = in_tdata[WEIGHT_BITS-1:0];
  assign store_wr  = in_acc && (op == gics_pkg::OP_LOAD) && (count_r < CNT_W'(CELL_COUNT));
  assign emit_ok   = !out_valid_r || out_tready;

  // target and scan arithmetic
  assign tot_ext   = PROD_W'(total_r);
  assign tgt_sum   = mul_p + PROD_W'(lo_prod_r[PROD_W-1:DATA_W])
                   + PROD_W'(lo_prod_r[DATA_W-1:0] != '0);
  assign scan_sum  = sum_r + TOT_W'(rdata_r);
  assign scan_hit  = (scan_sum >= target_r);
  assign scan_last = (CNT_W'(chk_r) == count_r - CNT_W'(1));
  assign addr_end  = (CNT_W'(addr_r) == count_r - CNT_W'(1));

  // centred offsets and step as multiplier operands
  assign off_i   = $signed(MUL_W'(ci_r)) - $signed(MUL_W'(CENTRE));
  assign off_j   = $signed(MUL_W'(cj_r)) - $signed(MUL_W'(CENTRE));
  assign off_k   = $signed(MUL_W'(ck_r)) - $signed(MUL_W'(CENTRE));
  assign step_op = $signed({1'b0, step_r});

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MLO: begin
        mul_a = $signed({1'b0, tot_ext[DATA_W-1:0]});
        mul_b = $signed({1'b0, frac_r});
      end
      ST_MHI: begin
        mul_a = $signed({1'b0, tot_ext[PROD_W-1:DATA_W]});
        mul_b = $signed({1'b0, frac_r});
      end
      ST_PX: begin
        mul_a = off_i;
        mul_b = step_op;
      end
      ST_PY: begin
        mul_a = off_j;
        mul_b = step_op;
      end
      ST_PZ: begin
        mul_a = off_k;
        mul_b = step_op;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  gics_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    step_nxt      = step_r;
    frac_nxt      = frac_r;
    lo_prod_nxt   = lo_prod_r;
    target_nxt    = target_r;
    sum_nxt       = sum_r;
    chk_nxt       = chk_r;
    addr_nxt      = addr_r;
    ci_nxt        = ci_r;
    cj_nxt        = cj_r;
    ck_nxt        = ck_r;
    fnd_s_nxt     = fnd_s_r;
    px_s_nxt      = px_s_r;
    py_s_nxt      = py_s_r;
    pz_s_nxt      = pz_s_r;
    w_s_nxt       = w_s_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (cfg_wr_en) begin
      step_nxt = cfg_wr_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (op)
            gics_pkg::OP_LOAD: begin
              if (store_wr) begin
                count_nxt = count_r + CNT_W'(1);
                total_nxt = total_r + TOT_W'(in_weight);
              end
            end
            gics_pkg::OP_CLEAR: begin
              count_nxt = '0;
              total_nxt = '0;
            end
            gics_pkg::OP_SAMPLE: begin
              frac_nxt = in_tdata[gics_pkg::IN_TDATA_W-1:DATA_W];
              sum_nxt  = '0;
              chk_nxt  = '0;
              addr_nxt = '0;
              ci_nxt   = '0;
              cj_nxt   = '0;
              ck_nxt   = '0;
              if (count_r == '0) begin
                // empty grid: all-zero result, not found
                fnd_s_nxt = 1'b0;
                px_s_nxt  = '0;
                py_s_nxt  = '0;
                pz_s_nxt  = '0;
                w_s_nxt   = '0;
                state_nxt = ST_EMIT;
              end else begin
                fnd_s_nxt = 1'b1;
                state_nxt = ST_MLO;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_MLO: begin
        state_nxt = ST_MHI;
      end
      ST_MHI: begin
        lo_prod_nxt = mul_p;
        state_nxt   = ST_MHI == state_r ? ST_TGT : ST_IDLE;
      end
      ST_TGT: begin
        // target = ceil(total * f / 2^32); first store read is under way
        target_nxt = tgt_sum[TOT_W-1:0];
        addr_nxt   = addr_end ? addr_r : addr_r + IDX_W'(1);
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_hit || scan_last) begin
          w_s_nxt   = rdata_r;
          state_nxt = ST_PX;
        end else begin
          sum_nxt  = scan_sum;
          chk_nxt  = chk_r + IDX_W'(1);
          addr_nxt = addr_end ? addr_r : addr_r + IDX_W'(1);
          // walk i,j,k with k fastest
          if (ck_r == COORD_W'(POINTS_PER_DIM - 1)) begin
            ck_nxt = '0;
            if (cj_r == COORD_W'(POINTS_PER_DIM - 1)) begin
              cj_nxt = '0;
              ci_nxt = ci_r + COORD_W'(1);
            end else begin
              cj_nxt = cj_r + COORD_W'(1);
            end
          end else begin
            ck_nxt = ck_r + COORD_W'(1);
          end
        end
      end
      ST_PX: begin
        state_nxt = ST_PY;
      end
      ST_PY: begin
        px_s_nxt  = mul_p[POS_W-1:0];
        state_nxt = ST_PZ;
      end
      ST_PZ: begin
        py_s_nxt  = mul_p[POS_W-1:0];
        state_nxt = ST_PW;
      end
      ST_PW: begin
        pz_s_nxt  = mul_p[POS_W-1:0];
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      step_r      <= DATA_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and staging registers
  always_ff @(posedge clk) begin
    frac_r    <= frac_nxt;
    lo_prod_r <= lo_prod_nxt;
    target_r  <= target_nxt;
    sum_r     <= sum_nxt;
    chk_r     <= chk_nxt;
    addr_r    <= addr_nxt;
    ci_r      <= ci_nxt;
    cj_r      <= cj_nxt;
    ck_r      <= ck_nxt;
    fnd_s_r   <= fnd_s_nxt;
    px_s_r    <= px_s_nxt;
    py_s_r    <= py_s_nxt;
    pz_s_r    <= pz_s_nxt;
    w_s_r     <= w_s_nxt;
  end

  // result register, loaded when the previous word has left
  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT) && emit_ok) begin
      out_found_r <= fnd_s_r;
      out_x_r     <= px_s_r;
      out_y_r     <= py_s_r;
      out_z_r     <= pz_s_r;
      out_w_r     <= w_s_r;
    end
  end

  // weight store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store_wr) begin
      mem[count_r[IDX_W-1:0]] <= in_weight;
    end
    rdata_r <= mem[addr_r];
  end

  // output packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {1'b0, DATA_W'(out_w_r), out_z_r, out_y_r, out_x_r};

  // checks
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CELL_COUNT))
    else $error("loaded count beyond grid size");

  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (total_r == '0))
    else $error("non-zero total with empty grid");

  // the first cell is always examined, later ones only while below the target
  a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |->
      ((CNT_W'(chk_r) < count_r) && ((chk_r == '0) || (sum_r < target_r))))
    else $error("scan ran past the loaded cells or the target");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && emit_ok) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished sample not presented");

endmodule : grid_inverse_cdf_sampler

`default_nettype wire
